FILE: design/etmp_pkg.sv
package etmp_pkg;

    // Bus event codes.
    typedef enum logic [1:0] {
        KIND_FETCH     = 2'd0,
        KIND_READ      = 2'd1,
        KIND_WRITE     = 2'd2,
        KIND_CTRL_PORT = 2'd3
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_RAM_BANK_BITS       = 2'd0,
        CFG_AUTO_PAGING_ALLOWED = 2'd1,
        CFG_ROM_WRITE_JUMPER    = 2'd2
    } cfg_index_t;

    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 8;
    localparam int OFFSET_W     = 19;
    localparam int CFG_W        = 3;
    localparam int BANK_W       = 6;
    localparam int BANK_OFS_W   = 13;    // 8192-byte banks
    localparam int CONMEM_BIT   = 7;
    localparam int MAPRAM_BIT   = 6;

    localparam logic [BANK_W-1:0] MAPRAM_BANK = 6'd3;

    // Bank mask for the configured number of bank bits, clamped to 2..6.
    function automatic logic [BANK_W-1:0] bank_mask(input logic [CFG_W-1:0] bits);
        logic [BANK_W-1:0] mask;
        case (bits)
            3'd0, 3'd1, 3'd2: mask = 6'b000011;
            3'd3:             mask = 6'b000111;
            3'd4:             mask = 6'b001111;
            3'd5:             mask = 6'b011111;
            default:          mask = 6'b111111;
        endcase
        return mask;
    endfunction

    // Fixed trap addresses that page the overlay in after the fetch.
    function automatic logic is_entry_point(input logic [ADDR_W-1:0] a);
        return (a == 16'h0000) || (a == 16'h0008) || (a == 16'h0038) ||
               (a == 16'h0066) || (a == 16'h04c6) || (a == 16'h0562);
    endfunction

endpackage

FILE: design/etmp_in_if.sv
interface etmp_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      kind;
    logic [etmp_pkg::ADDR_W-1:0]     address;
    logic [etmp_pkg::DATA_W-1:0]     write_data;

    modport source (output valid, output kind, output address, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input address, input write_data,
                    output ready);
endinterface

FILE: design/etmp_out_if.sv
interface etmp_out_if;
    logic                            valid;
    logic                            ready;
    logic                            overlay_hit;
    logic                            target_is_ram;
    logic [etmp_pkg::OFFSET_W-1:0]   target_offset;
    logic                            write_enable;
    logic                            paged_after;

    modport source (output valid, output overlay_hit, output target_is_ram,
                    output target_offset, output write_enable, output paged_after,
                    input ready);
    modport sink   (input valid, input overlay_hit, input target_is_ram,
                    input target_offset, input write_enable, input paged_after,
                    output ready);
endinterface

FILE: design/entry_trap_memory_paging.sv
// Overlay paging unit for an 8-bit CPU bus. Each input beat is one bus event
// (opcode fetch, memory read, memory write or control port write); each event
// yields exactly one result beat telling whether the overlay answers below
// 4000h, whether overlay ROM or RAM is selected, the byte offset inside it,
// whether a write must update the overlay, and the automatic-paging flag after
// the event. The unit sustains one event per clock cycle when the output side
// does not stall: an event is held in the input register while the decode
// (address compares, bank mask and offset assembly) runs, and its result is
// captured in the output register, from which it is presented on the output
// and taken at an edge on which the output side is ready. The control byte and
// paging flag are updated at the same edge that moves an event into the
// output register, so the next event decodes against them immediately.
// Configuration writes take effect at the edge on which cfg_we is high and
// must only be issued while idle.
module entry_trap_memory_paging (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [etmp_pkg::CFG_W-1:0]     cfg_data,
    etmp_in_if.sink                        in_ch,
    etmp_out_if.source                     out_ch
);

    // Configuration registers.
    logic [etmp_pkg::CFG_W-1:0] ram_bank_bits_reg;
    logic                       auto_paging_allowed_reg;
    logic                       rom_write_jumper_reg;

    // Block state.
    logic [etmp_pkg::DATA_W-1:0] control_byte_reg, control_byte_next;
    logic                        auto_paged_reg, auto_paged_next;

    // Input register.
    logic                        s1_valid_reg;
    logic [1:0]                  s1_kind_reg;
    logic [etmp_pkg::ADDR_W-1:0] s1_addr_reg;
    logic [etmp_pkg::DATA_W-1:0] s1_data_reg;

    // Output register.
    logic                          out_valid_reg;
    logic                          hit_reg, hit_next;
    logic                          is_ram_reg, is_ram_next;
    logic [etmp_pkg::OFFSET_W-1:0] offset_reg, offset_next;
    logic                          we_reg, we_next;
    logic                          paged_reg;

    logic s1_advance;
    logic in_accept;

    // The decode stage moves forward whenever the output register is free or
    // being emptied this cycle; the input register refills on the same edge.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_advance;
    assign in_accept   = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_bank_bits_reg       <= 3'd4;
            auto_paging_allowed_reg <= 1'b1;
            rom_write_jumper_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                etmp_pkg::CFG_RAM_BANK_BITS:       ram_bank_bits_reg       <= cfg_data;
                etmp_pkg::CFG_AUTO_PAGING_ALLOWED: auto_paging_allowed_reg <= cfg_data[0];
                etmp_pkg::CFG_ROM_WRITE_JUMPER:    rom_write_jumper_reg    <= cfg_data[0];
                default:                           ;
            endcase
        end
    end

    // Decode of the event held in the input register.
    always_comb
    begin
        logic                      conmem;
        logic                      mapram;
        logic                      fetch_trap;
        logic                      set_after;
        logic                      clear_after;
        logic                      paged_now;
        logic [etmp_pkg::BANK_W-1:0] bank;

        conmem      = control_byte_reg[etmp_pkg::CONMEM_BIT];
        mapram      = control_byte_reg[etmp_pkg::MAPRAM_BIT];
        fetch_trap  = (s1_kind_reg == etmp_pkg::KIND_FETCH) && auto_paging_allowed_reg;
        set_after   = fetch_trap && etmp_pkg::is_entry_point(s1_addr_reg) && !auto_paged_reg;
        clear_after = fetch_trap && (s1_addr_reg[15:3] == 13'h03ff) && auto_paged_reg;
        // Fetches from 3D00-3DFF page in before the fetch is decoded.
        paged_now   = auto_paged_reg ||
                      (fetch_trap && (s1_addr_reg[15:8] == 8'h3d));
        bank        = control_byte_reg[etmp_pkg::BANK_W-1:0] &
                      etmp_pkg::bank_mask(ram_bank_bits_reg);

        control_byte_next = control_byte_reg;
        auto_paged_next   = auto_paged_reg;
        hit_next          = 1'b0;
        is_ram_next       = 1'b0;
        offset_next       = '0;
        we_next           = 1'b0;

        if (s1_kind_reg == etmp_pkg::KIND_CTRL_PORT)
        begin
            control_byte_next = s1_data_reg;
        end
        else
        begin
            if ((conmem || paged_now) && (s1_addr_reg[15:14] == 2'b00))
            begin
                hit_next = 1'b1;
                if (!s1_addr_reg[13])
                begin
                    // Lower 8K: ROM, or RAM bank 3 under MAPRAM.
                    if (!conmem && mapram)
                    begin
                        is_ram_next = 1'b1;
                        offset_next = {etmp_pkg::MAPRAM_BANK,
                                       s1_addr_reg[etmp_pkg::BANK_OFS_W-1:0]};
                    end
                    else
                    begin
                        offset_next = {{etmp_pkg::BANK_W{1'b0}},
                                       s1_addr_reg[etmp_pkg::BANK_OFS_W-1:0]};
                    end
                    we_next = (s1_kind_reg == etmp_pkg::KIND_WRITE) && conmem &&
                              rom_write_jumper_reg;
                end
                else
                begin
                    // Upper 8K: selected RAM bank; bank 3 is read-only under MAPRAM.
                    is_ram_next = 1'b1;
                    offset_next = {bank, s1_addr_reg[etmp_pkg::BANK_OFS_W-1:0]};
                    we_next     = (s1_kind_reg == etmp_pkg::KIND_WRITE) &&
                                  !(mapram && !conmem && (bank == etmp_pkg::MAPRAM_BANK));
                end
            end
            auto_paged_next = paged_now;
            if (set_after)
            begin
                auto_paged_next = 1'b1;
            end
            if (clear_after)
            begin
                auto_paged_next = 1'b0;
            end
        end
    end

    // Control state and pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_byte_reg <= '0;
            auto_paged_reg   <= 1'b0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                control_byte_reg <= control_byte_next;
                auto_paged_reg   <= auto_paged_next;
            end
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_accept;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg <= in_ch.kind;
            s1_addr_reg <= in_ch.address;
            s1_data_reg <= in_ch.write_data;
        end
        if (s1_advance)
        begin
            hit_reg    <= hit_next;
            is_ram_reg <= is_ram_next;
            offset_reg <= offset_next;
            we_reg     <= we_next;
            paged_reg  <= auto_paged_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.overlay_hit   = hit_reg;
    assign out_ch.target_is_ram = is_ram_reg;
    assign out_ch.target_offset = offset_reg;
    assign out_ch.write_enable  = we_reg;
    assign out_ch.paged_after   = paged_reg;

    // A miss carries no target and no write.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hit_reg) |-> (!is_ram_reg && (offset_reg == '0) && !we_reg))
        else $error("result without hit carries a target");

    // The reported flag matches the stored flag right after a result is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> (paged_reg == auto_paged_reg))
        else $error("paged_after differs from stored paging flag");

    // State only moves when an event is retired into the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> ($stable(auto_paged_reg) && $stable(control_byte_reg)))
        else $error("paging state changed without an event");

    // A held decode item is not dropped while the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ch.ready) |=> s1_valid_reg)
        else $error("stalled event lost from input register");

    // Input is refused only when the input register is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> s1_valid_reg)
        else $error("input stalled with empty input register");

endmodule

FILE: test/entry_trap_memory_paging_tb.sv
module entry_trap_memory_paging_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The run is stopped here whatever happens. This is far above what the slowest
    // correct run needs: about 1600 events, each with the longest sender gap and
    // the longest result stall.
    localparam int CYCLE_LIMIT = 1_000_000;

    // One decoded bus event as the block reports it, packed so that a whole
    // result can be compared at once and printed field by field.
    typedef struct packed {
        logic                          hit;
        logic                          is_ram;
        logic [etmp_pkg::OFFSET_W-1:0] offset;
        logic                          we;
        logic                          paged;
    } page_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [1:0]                    cfg_index;
    logic [etmp_pkg::CFG_W-1:0]    cfg_data;

    etmp_in_if  in_ch();
    etmp_out_if out_ch();

    entry_trap_memory_paging dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Decodes predicted for accepted events, oldest first.
    page_result_t expected_pages[$];

    // Our own copy of the paging state and of the three configuration registers.
    logic [7:0] model_ctrl;
    logic       model_paged;
    logic [2:0] model_bank_bits;
    logic       model_traps_on;
    logic       model_jumper;

    int  mismatches;
    int  items_sent;
    int  results_checked;
    int  config_writes;
    int  cycle_count;
    bit  gaps_off;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles: %0d events sent, %0d results seen",
                     cycle_count, items_sent, results_checked);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The six fixed trap addresses that page the overlay in after the fetch.
    function automatic logic [15:0] trap_addr(input int i);
        case (i)
            0:       return 16'h0000;
            1:       return 16'h0008;
            2:       return 16'h0038;
            3:       return 16'h0066;
            4:       return 16'h04c6;
            default: return 16'h0562;
        endcase
    endfunction

    // Works out the result of one bus event and advances the predicted state.
    // The decode of a fetch sees the flag after the before-fetch trap (3D00-3DFF)
    // but before the after-fetch traps (entry points set, 1FF8-1FFF clears).
    function automatic page_result_t predict_event(input etmp_pkg::kind_t kind,
                                                   input logic [15:0] a,
                                                   input logic [7:0] d);
        page_result_t r;
        logic         conmem;
        logic         mapram;
        logic         set_after;
        logic         clear_after;
        logic [5:0]   mask;
        logic [5:0]   bank;
        int           nbits;
        r           = '0;
        set_after   = 1'b0;
        clear_after = 1'b0;
        if (kind == etmp_pkg::KIND_CTRL_PORT)
        begin
            model_ctrl = d;
        end
        else
        begin
            conmem = model_ctrl[etmp_pkg::CONMEM_BIT];
            mapram = model_ctrl[etmp_pkg::MAPRAM_BIT];
            if (kind == etmp_pkg::KIND_FETCH && model_traps_on)
            begin
                for (int i = 0; i < 6; i++)
                    if (a == trap_addr(i) && !model_paged)
                        set_after = 1'b1;
                if (a >= 16'h1ff8 && a <= 16'h1fff && model_paged)
                    clear_after = 1'b1;
                if (a[15:8] == 8'h3d)
                    model_paged = 1'b1;
            end
            if ((conmem || model_paged) && a < 16'h4000)
            begin
                r.hit = 1'b1;
                if (!a[13])
                begin
                    // Lower 8K: ROM, or RAM bank 3 when MAPRAM stands in for it.
                    if (!conmem && mapram)
                    begin
                        r.is_ram = 1'b1;
                        r.offset = {6'd3, a[12:0]};
                    end
                    else
                    begin
                        r.offset = {3'b000, a};
                    end
                    r.we = (kind == etmp_pkg::KIND_WRITE) && conmem && model_jumper;
                end
                else
                begin
                    // Upper 8K: the selected RAM bank. Bank bits outside 2..6 clamp.
                    nbits    = (model_bank_bits < 3'd2) ? 2 :
                               (model_bank_bits > 3'd6) ? 6 : int'(model_bank_bits);
                    mask     = (6'd1 << nbits) - 6'd1;
                    bank     = model_ctrl[5:0] & mask;
                    r.is_ram = 1'b1;
                    r.offset = {bank, a[12:0]};
                    r.we     = (kind == etmp_pkg::KIND_WRITE) &&
                               !(mapram && !conmem && bank == 6'd3);
                end
            end
            if (set_after)
                model_paged = 1'b1;
            if (clear_after)
                model_paged = 1'b0;
        end
        r.paged = model_paged;
        return r;
    endfunction

    // Scoreboard. Results are checked before the new event is queued, since a
    // result leaving at an edge can never belong to the event entering there.
    always @(posedge clk)
    begin
        page_result_t got;
        page_result_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_checked++;
                got.hit    = out_ch.overlay_hit;
                got.is_ram = out_ch.target_is_ram;
                got.offset = out_ch.target_offset;
                got.we     = out_ch.write_enable;
                got.paged  = out_ch.paged_after;
                if (expected_pages.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result beat with no event waiting:", $realtime,
                                 " hit=%b ram=%b ofs=%05h we=%b paged=%b",
                                 got.hit, got.is_ram, got.offset, got.we, got.paged);
                    mismatches++;
                end
                else
                begin
                    want = expected_pages.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: result %0d differs", $realtime, results_checked);
                            $display("    expected hit=%b ram=%b ofs=%05h we=%b paged=%b",
                                     want.hit, want.is_ram, want.offset, want.we, want.paged);
                            $display("    actual   hit=%b ram=%b ofs=%05h we=%b paged=%b",
                                     got.hit, got.is_ram, got.offset, got.we, got.paged);
                        end
                        mismatches++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_pages.push_back(predict_event(etmp_pkg::kind_t'(in_ch.kind),
                                                       in_ch.address, in_ch.write_data));
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // The result side stalls at random, with occasional long stretches of
    // steady ready so that back-to-back results are seen as well.
    initial
    begin
        out_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(50, 200)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            out_ch.ready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clk);
        end
    end

    // Unless gaps_off is set, drops valid for a random number of cycles after a
    // beat. With no gap, valid simply stays high into the next beat.
    task automatic idle_gap();
        int g;
        g = pick_gap();
        if (g > 0 && !gaps_off)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Presents one bus event and holds it until the block takes the beat.
    task automatic send_event(input etmp_pkg::kind_t kind, input logic [15:0] a,
                              input logic [7:0] d);
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.address    <= a;
        in_ch.write_data <= d;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
        idle_gap();
    endtask

    // Stops sending and waits until every event has produced its result and the
    // block is idle.
    task automatic drain_events();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_checked < items_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Configuration is only changed with nothing in flight, so the predictor can
    // take the new value at the same edge as the block.
    task automatic write_config(input etmp_pkg::cfg_index_t idx, input logic [2:0] value);
        drain_events();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            etmp_pkg::CFG_RAM_BANK_BITS:       model_bank_bits = value;
            etmp_pkg::CFG_AUTO_PAGING_ALLOWED: model_traps_on  = value[0];
            default:                           model_jumper    = value[0];
        endcase
        config_writes++;
    endtask

    // Addresses weighted toward the places where the decode changes.
    function automatic logic [15:0] random_address();
        case ($urandom_range(0, 9))
            0:       return trap_addr($urandom_range(0, 5));
            1:       return 16'h1ff8 + 16'($urandom_range(0, 7));
            2:       return {8'h3d, 8'($urandom)};
            3, 4:    return 16'($urandom_range(0, 16'h1fff));
            5, 6:    return 16'($urandom_range(16'h2000, 16'h3fff));
            7:
            begin
                case ($urandom_range(0, 6))
                    0:       return 16'h1fff;
                    1:       return 16'h2000;
                    2:       return 16'h3fff;
                    3:       return 16'h4000;
                    4:       return 16'h3cff;
                    5:       return 16'h3e00;
                    default: return 16'h1ff7;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    // A single event of any kind, anywhere: the noise between overlay calls.
    task automatic send_stray_event();
        send_event(etmp_pkg::kind_t'($urandom_range(0, 3)), random_address(), 8'($urandom));
    endtask

    // A well-formed trip into the overlay: perhaps a new control byte, a fetch
    // from an entry point or from 3Dxx, some traffic below 4000h, and a fetch
    // from the 1FF8-1FFF exit window. Body fetches never touch the exit window,
    // so the overlay stays paged until the exit.
    task automatic run_overlay_call();
        int              body;
        logic [15:0]     a;
        etmp_pkg::kind_t k;
        body = $urandom_range(2, 10);
        if ($urandom_range(0, 3) == 0)
            send_event(etmp_pkg::KIND_CTRL_PORT, 16'($urandom),
                       {($urandom_range(0, 3) == 0), 7'($urandom)});
        if ($urandom_range(0, 3) == 0)
            send_event(etmp_pkg::KIND_FETCH, {8'h3d, 8'($urandom)}, 8'($urandom));
        else
            send_event(etmp_pkg::KIND_FETCH, trap_addr($urandom_range(0, 5)), 8'($urandom));
        repeat (body)
        begin
            k = etmp_pkg::kind_t'($urandom_range(0, 2));
            a = 16'($urandom_range(0, 16'h3fff));
            if (k == etmp_pkg::KIND_FETCH && a >= 16'h1ff8 && a <= 16'h1fff)
                k = etmp_pkg::KIND_READ;
            send_event(k, a, 8'($urandom));
        end
        send_event(etmp_pkg::KIND_FETCH, 16'h1ff8 + 16'($urandom_range(0, 7)), 8'($urandom));
    endtask

    // With the reset configuration (traps on), every entry point pages the
    // overlay in and a fetch from the exit window pages it out again. The 3Dxx
    // window pages in before its own fetch, so that fetch already hits.
    task automatic test_entry_traps();
        send_event(etmp_pkg::KIND_READ, 16'h0000, 8'hff);
        for (int i = 0; i < 6; i++)
        begin
            send_event(etmp_pkg::KIND_FETCH, trap_addr(i), 8'h00);
            send_event(etmp_pkg::KIND_FETCH, 16'h1ff8 + 16'(i), 8'h00);
        end
        send_event(etmp_pkg::KIND_FETCH, 16'h3d00, 8'h00);
        send_event(etmp_pkg::KIND_FETCH, 16'h1fff, 8'h00);
        send_event(etmp_pkg::KIND_FETCH, 16'h3dff, 8'h00);
        send_event(etmp_pkg::KIND_FETCH, 16'h1ffe, 8'h00);
    endtask

    // Manual mapping through the control byte: CONMEM with a bank number wider
    // than the bank mask, writes to ROM without the jumper, then MAPRAM, where
    // bank 3 stands in for the ROM and is write-protected in the upper half.
    task automatic test_control_decode();
        send_event(etmp_pkg::KIND_CTRL_PORT, 16'hffff, 8'hbf);
        send_event(etmp_pkg::KIND_READ,  16'h0000, 8'h00);
        send_event(etmp_pkg::KIND_WRITE, 16'h1fff, 8'hff);
        send_event(etmp_pkg::KIND_WRITE, 16'h2000, 8'h5a);
        send_event(etmp_pkg::KIND_READ,  16'h3fff, 8'ha5);
        send_event(etmp_pkg::KIND_WRITE, 16'h4000, 8'h00);
        send_event(etmp_pkg::KIND_CTRL_PORT, 16'h0000, 8'h43);
        send_event(etmp_pkg::KIND_FETCH, 16'h0038, 8'h00);
        send_event(etmp_pkg::KIND_READ,  16'h0100, 8'h00);
        send_event(etmp_pkg::KIND_WRITE, 16'h1234, 8'h77);
        send_event(etmp_pkg::KIND_WRITE, 16'h2100, 8'h88);
        send_event(etmp_pkg::KIND_CTRL_PORT, 16'h0000, 8'h00);
        send_event(etmp_pkg::KIND_FETCH, 16'h1ff9, 8'h00);
    endtask

    // Every bank-bit setting, including the out-of-range ones that clamp, with
    // traps and the ROM write jumper each taking both values along the way.
    task automatic test_config_sweep();
        int start;
        for (int bits = 0; bits < 8; bits++)
        begin
            write_config(etmp_pkg::CFG_RAM_BANK_BITS, 3'(bits));
            write_config(etmp_pkg::CFG_AUTO_PAGING_ALLOWED, {2'($urandom), 1'(bits >> 1)});
            write_config(etmp_pkg::CFG_ROM_WRITE_JUMPER, {2'($urandom), 1'(bits >> 2)});
            start = items_sent;
            while (items_sent - start < 60)
            begin
                if ($urandom_range(0, 3) != 0)
                    run_overlay_call();
                else
                    send_stray_event();
            end
        end
    endtask

    // The bulk of the run: overlay calls with random content and some noise,
    // under random settings. Some phases run with the sender never idling.
    task automatic test_overlay_calls();
        int start;
        for (int phase = 0; phase < 7; phase++)
        begin
            write_config(etmp_pkg::CFG_RAM_BANK_BITS, 3'($urandom));
            write_config(etmp_pkg::CFG_AUTO_PAGING_ALLOWED,
                         {2'($urandom), 1'($urandom_range(0, 6) != 0)});
            write_config(etmp_pkg::CFG_ROM_WRITE_JUMPER, 3'($urandom));
            gaps_off = ($urandom_range(0, 3) == 0);
            start    = items_sent;
            while (items_sent - start < 150)
            begin
                if ($urandom_range(0, 4) != 0)
                    run_overlay_call();
                else
                    send_stray_event();
            end
        end
        gaps_off = 1'b0;
    endtask

    initial
    begin
        cfg_we           = 1'b0;
        cfg_index        = etmp_pkg::CFG_RAM_BANK_BITS;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.kind       = etmp_pkg::KIND_FETCH;
        in_ch.address    = '0;
        in_ch.write_data = '0;
        model_ctrl       = 8'h00;
        model_paged      = 1'b0;
        model_bank_bits  = 3'd4;
        model_traps_on   = 1'b1;
        model_jumper     = 1'b0;
        gaps_off         = 1'b0;
        rst_n            = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_entry_traps();
        test_control_decode();
        test_config_sweep();
        test_overlay_calls();

        // Let the pipeline empty, then give any stray result time to show up.
        drain_events();
        repeat (10) @(posedge clk);
        if (expected_pages.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_pages.size());
            mismatches += expected_pages.size();
        end

        $display("Checked %0d bus events against %0d results, %0d mismatches.",
                 items_sent, results_checked, mismatches);
        $display("Covered %0d register writes: every bank-bit setting, %s",
                 config_writes, "traps and jumper on and off.");
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
